// File: hw/rtl/sha256_stream_hash_defines.svh
// ----------------------------------------------------------------------------
// sha256_stream_hash_defines.svh
// Assertion macros shared by the stream hash modules.
// ----------------------------------------------------------------------------
`ifndef SHA256_STREAM_HASH_DEFINES_SVH
`define SHA256_STREAM_HASH_DEFINES_SVH
`ifndef SYNTHESIS
// Same-cycle implication checked on every rising clock edge outside reset.
`define SHS_ASSERT_IMPL(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
// Next-cycle implication checked on every rising clock edge outside reset.
`define SHS_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`else
`define SHS_ASSERT_IMPL(lbl, clk, rst, ante, cons, msg)
`define SHS_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg)
`endif
`endif

// File: hw/rtl/sha256sh_pkg.sv
// ----------------------------------------------------------------------------
// sha256sh_pkg
// Types, round constants and bit functions of the SHA-256 stream hash.
// ----------------------------------------------------------------------------
package sha256sh_pkg;

   localparam int LEN_W = 61;
   localparam logic [LEN_W-1:0] LEN_MAX = {LEN_W{1'b1}};
   localparam logic [5:0] LAST_POS = 6'd63;
   localparam logic [5:0] ROOM_POS = 6'd55;
   localparam logic [7:0] PAD_BYTE = 8'h80;

   localparam logic [31:0] IV_TABLE [8] = '{
      32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
      32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
   };

   localparam logic [31:0] K_TABLE [64] = '{
      32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
      32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
      32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
      32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
      32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
      32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
      32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
      32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
      32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
      32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
      32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
      32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
      32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
      32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
      32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
      32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
   };

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic accept;
      logic start_run;
      logic start_pad1;
      logic start_pad2;
      logic round;
      logic fin_run;
      logic fin_pad;
      logic next_word;
   } cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic full;
      logic need_two;
      logic rnd_last;
      logic word_last;
   } sts_type;

   function automatic logic [31:0] big_sig0(input logic [31:0] x);
      return {x[1:0], x[31:2]} ^ {x[12:0], x[31:13]} ^ {x[21:0], x[31:22]};
   endfunction

   function automatic logic [31:0] big_sig1(input logic [31:0] x);
      return {x[5:0], x[31:6]} ^ {x[10:0], x[31:11]} ^ {x[24:0], x[31:25]};
   endfunction

   function automatic logic [31:0] sml_sig0(input logic [31:0] x);
      return {x[6:0], x[31:7]} ^ {x[17:0], x[31:18]} ^ {3'b000, x[31:3]};
   endfunction

   function automatic logic [31:0] sml_sig1(input logic [31:0] x);
      return {x[16:0], x[31:17]} ^ {x[18:0], x[31:19]} ^ {10'b0, x[31:10]};
   endfunction

   // Byte lane of a byte position inside its big-endian word.
   function automatic logic [31:0] lane(input logic [1:0] p, input logic [7:0] b);
      logic [31:0] r;
      case (p)
         2'd0: r = {b, 24'h0};
         2'd1: r = {8'h0, b, 16'h0};
         2'd2: r = {16'h0, b, 8'h0};
         default: r = {24'h0, b};
      endcase
      return r;
   endfunction

endpackage

// File: hw/rtl/sha256sh_dp.sv
// ----------------------------------------------------------------------------
// sha256sh_dp
// Datapath: running hash, block buffer, length, round engine and digest.
// ----------------------------------------------------------------------------
`include "sha256_stream_hash_defines.svh"

module sha256sh_dp (
   input  logic                  clock,
   input  logic                  reset,
   input  sha256sh_pkg::cmd_type cmd,
   output sha256sh_pkg::sts_type sts,
   input  logic [7:0]            req_data_byte,
   input  logic                  req_byte_valid,
   input  logic                  req_start_message,
   output logic [31:0]           rsp_digest_word,
   output logic [2:0]            rsp_word_index,
   output logic                  rsp_last_word,
   output logic                  rsp_length_overflow
);

   logic [31:0] hash_ff [8];
   logic [31:0] buf_ff [16];
   logic [sha256sh_pkg::LEN_W-1:0] len_ff;
   logic ovf_ff;
   logic full_ff;
   logic [31:0] base_ff [8];
   logic [31:0] wv_ff [8];
   logic [31:0] w_ff [16];
   logic [5:0] rnd_ff;
   logic [2:0] idx_ff;

   logic [31:0] buf_in [16];
   logic [sha256sh_pkg::LEN_W-1:0] len_cur;
   logic [5:0] acc_pos;
   logic take;
   logic [5:0] pos;
   logic [63:0] bits;
   logic [31:0] pad1 [16];
   logic [31:0] pad2 [16];
   logic [31:0] sum [8];
   logic [31:0] t1;
   logic [31:0] t2;
   logic [31:0] w_new;

   // Absorb: restart first, then place the byte at the current position.
   always_comb begin
      len_cur = req_start_message ? '0 : len_ff;
      acc_pos = len_cur[5:0];
      take    = req_byte_valid && (len_cur != sha256sh_pkg::LEN_MAX);
      for (int i = 0; i < 16; i++) begin
         buf_in[i] = req_start_message ? 32'h0 : buf_ff[i];
         if (take && (acc_pos[5:2] == 4'(i))) begin
            buf_in[i] = buf_in[i] | sha256sh_pkg::lane(acc_pos[1:0], req_data_byte);
         end
      end
   end

   // Padded blocks. Bytes past the fill point are always zero in the buffer.
   always_comb begin
      pos  = len_ff[5:0];
      bits = {len_ff, 3'b000};
      for (int i = 0; i < 16; i++) begin
         pad1[i] = buf_ff[i];
         pad2[i] = 32'h0;
         if (pos[5:2] == 4'(i)) begin
            pad1[i] = buf_ff[i] | sha256sh_pkg::lane(pos[1:0], sha256sh_pkg::PAD_BYTE);
         end
      end
      pad2[14] = bits[63:32];
      pad2[15] = bits[31:0];
      if (pos <= sha256sh_pkg::ROOM_POS) begin
         pad1[14] = bits[63:32];
         pad1[15] = bits[31:0];
      end
   end

   // One compression round and the schedule word for sixteen rounds ahead.
   always_comb begin
      t1 = wv_ff[7] + sha256sh_pkg::big_sig1(wv_ff[4])
         + ((wv_ff[4] & wv_ff[5]) ^ (~wv_ff[4] & wv_ff[6]))
         + sha256sh_pkg::K_TABLE[rnd_ff] + w_ff[0];
      t2 = sha256sh_pkg::big_sig0(wv_ff[0])
         + ((wv_ff[0] & wv_ff[1]) ^ (wv_ff[0] & wv_ff[2]) ^ (wv_ff[1] & wv_ff[2]));
      w_new = w_ff[0] + sha256sh_pkg::sml_sig0(w_ff[1]) + w_ff[9]
            + sha256sh_pkg::sml_sig1(w_ff[14]);
      for (int i = 0; i < 8; i++) begin
         sum[i] = base_ff[i] + wv_ff[i];
      end
   end

   // State registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < 8; i++) begin
            hash_ff[i] <= sha256sh_pkg::IV_TABLE[i];
         end
         for (int i = 0; i < 16; i++) begin
            buf_ff[i] <= 32'h0;
         end
         len_ff  <= '0;
         ovf_ff  <= 1'b0;
         full_ff <= 1'b0;
         rnd_ff  <= '0;
         idx_ff  <= '0;
      end else begin
         if (cmd.accept) begin
            if (req_start_message) begin
               for (int i = 0; i < 8; i++) begin
                  hash_ff[i] <= sha256sh_pkg::IV_TABLE[i];
               end
            end
            for (int i = 0; i < 16; i++) begin
               buf_ff[i] <= buf_in[i];
            end
            len_ff  <= take ? len_cur + 1'b1 : len_cur;
            ovf_ff  <= (req_start_message ? 1'b0 : ovf_ff) | (req_byte_valid && !take);
            full_ff <= take && (acc_pos == sha256sh_pkg::LAST_POS);
         end
         if (cmd.start_run || cmd.start_pad1 || cmd.start_pad2) begin
            rnd_ff <= '0;
            idx_ff <= '0;
         end
         if (cmd.round) begin
            rnd_ff <= rnd_ff + 1'b1;
         end
         if (cmd.next_word) begin
            idx_ff <= idx_ff + 1'b1;
         end
         if (cmd.fin_run) begin
            for (int i = 0; i < 8; i++) begin
               hash_ff[i] <= sum[i];
            end
            for (int i = 0; i < 16; i++) begin
               buf_ff[i] <= 32'h0;
            end
            full_ff <= 1'b0;
         end
      end
   end

   // Round engine and chaining value.
   always_ff @(posedge clock) begin
      if (cmd.start_run || cmd.start_pad1) begin
         for (int i = 0; i < 8; i++) begin
            base_ff[i] <= hash_ff[i];
            wv_ff[i]   <= hash_ff[i];
         end
      end else if (cmd.start_pad2) begin
         for (int i = 0; i < 8; i++) begin
            wv_ff[i] <= base_ff[i];
         end
      end else if (cmd.round) begin
         wv_ff[0] <= t1 + t2;
         wv_ff[1] <= wv_ff[0];
         wv_ff[2] <= wv_ff[1];
         wv_ff[3] <= wv_ff[2];
         wv_ff[4] <= wv_ff[3] + t1;
         wv_ff[5] <= wv_ff[4];
         wv_ff[6] <= wv_ff[5];
         wv_ff[7] <= wv_ff[6];
      end else if (cmd.fin_run || cmd.fin_pad) begin
         for (int i = 0; i < 8; i++) begin
            base_ff[i] <= sum[i];
         end
      end
      // Message schedule window.
      if (cmd.start_run) begin
         for (int i = 0; i < 16; i++) begin
            w_ff[i] <= buf_ff[i];
         end
      end else if (cmd.start_pad1) begin
         for (int i = 0; i < 16; i++) begin
            w_ff[i] <= pad1[i];
         end
      end else if (cmd.start_pad2) begin
         for (int i = 0; i < 16; i++) begin
            w_ff[i] <= pad2[i];
         end
      end else if (cmd.round) begin
         for (int i = 0; i < 15; i++) begin
            w_ff[i] <= w_ff[i+1];
         end
         w_ff[15] <= w_new;
      end
   end

   // Status and result ports.
   assign sts.full      = full_ff;
   assign sts.need_two  = (pos > sha256sh_pkg::ROOM_POS);
   assign sts.rnd_last  = (rnd_ff == sha256sh_pkg::LAST_POS);
   assign sts.word_last = (idx_ff == 3'd7);

   assign rsp_digest_word     = base_ff[idx_ff];
   assign rsp_word_index      = idx_ff;
   assign rsp_last_word       = (idx_ff == 3'd7);
   assign rsp_length_overflow = ovf_ff;

   `SHS_ASSERT_IMPL(a_full_aligned, clock, reset, full_ff, len_ff[5:0] == 6'd0, "full block not aligned")
   `SHS_ASSERT_IMPL(a_fin_after_64, clock, reset, cmd.fin_run || cmd.fin_pad, rnd_ff == 6'd0, "compression finished early")
   `SHS_ASSERT_NEXT(a_ovf_sticky, clock, reset, ovf_ff && !(cmd.accept && req_start_message), ovf_ff, "overflow flag lost")

endmodule

// File: hw/rtl/sha256sh_ctrl.sv
// ----------------------------------------------------------------------------
// sha256sh_ctrl
// Controller: sequences absorb, block compression, padding and digest beats.
// ----------------------------------------------------------------------------
`include "sha256_stream_hash_defines.svh"

module sha256sh_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  logic                  req_emit_digest,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output sha256sh_pkg::cmd_type cmd,
   input  sha256sh_pkg::sts_type sts
);

   typedef enum logic [7:0] {
      S_IDLE    = 8'b0000_0001,
      S_CHECK   = 8'b0000_0010,
      S_RUN     = 8'b0000_0100,
      S_FIN_RUN = 8'b0000_1000,
      S_PAD1    = 8'b0001_0000,
      S_PAD2    = 8'b0010_0000,
      S_FIN_PAD = 8'b0100_0000,
      S_OUT     = 8'b1000_0000
   } state_type;

   state_type state_ff, state_in;
   logic emit_ff, emit_in;
   logic pad_ff, pad_in;
   logic second_ff, second_in;

   assign req_ready = (state_ff == S_IDLE);
   assign rsp_valid = (state_ff == S_OUT);

   // Next state and command decode.
   always_comb begin
      state_in  = state_ff;
      emit_in   = emit_ff;
      pad_in    = pad_ff;
      second_in = second_ff;
      cmd       = '0;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.accept = 1'b1;
               emit_in    = req_emit_digest;
               state_in   = S_CHECK;
            end
         end
         S_CHECK: begin
            if (sts.full) begin
               cmd.start_run = 1'b1;
               pad_in        = 1'b0;
               state_in      = S_RUN;
            end else if (emit_ff) begin
               state_in = S_PAD1;
            end else begin
               state_in = S_IDLE;
            end
         end
         S_RUN: begin
            cmd.round = 1'b1;
            if (sts.rnd_last) begin
               state_in = pad_ff ? S_FIN_PAD : S_FIN_RUN;
            end
         end
         S_FIN_RUN: begin
            cmd.fin_run = 1'b1;
            state_in    = emit_ff ? S_PAD1 : S_IDLE;
         end
         S_PAD1: begin
            cmd.start_pad1 = 1'b1;
            pad_in         = 1'b1;
            second_in      = 1'b0;
            state_in       = S_RUN;
         end
         S_PAD2: begin
            cmd.start_pad2 = 1'b1;
            second_in      = 1'b1;
            state_in       = S_RUN;
         end
         S_FIN_PAD: begin
            cmd.fin_pad = 1'b1;
            state_in    = (sts.need_two && !second_ff) ? S_PAD2 : S_OUT;
         end
         S_OUT: begin
            if (rsp_ready) begin
               cmd.next_word = 1'b1;
               if (sts.word_last) begin
                  state_in = S_IDLE;
               end
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= S_IDLE;
         emit_ff   <= 1'b0;
         pad_ff    <= 1'b0;
         second_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         emit_ff   <= emit_in;
         pad_ff    <= pad_in;
         second_ff <= second_in;
      end
   end

   `SHS_ASSERT_IMPL(a_no_overlap, clock, reset, rsp_valid, !req_ready, "accepting during digest output")
   `SHS_ASSERT_NEXT(a_accept_check, clock, reset, req_valid && req_ready, state_ff == S_CHECK, "accepted beat not checked")
   `SHS_ASSERT_NEXT(a_run_ends, clock, reset, state_ff == S_RUN && sts.rnd_last, state_ff == S_FIN_RUN || state_ff == S_FIN_PAD, "rounds did not finish")

endmodule

// File: hw/rtl/sha256_stream_hash.sv
// Each input beat passes through a check state; one that completes a 64-byte block also
// runs a compression. A digest request runs one or two padding compressions before its
// eight result beats, which then leave at one per cycle while rsp_ready is high.
// The single round engine (one round per cycle, 64 per block) sets the throughput.
// Synchronous active-high reset loads the initial hash and clears buffer and length.
// ----------------------------------------------------------------------------
// sha256_stream_hash
// Incremental SHA-256 over a byte stream with on-demand digest output.
// ----------------------------------------------------------------------------
module sha256_stream_hash (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [7:0]  req_data_byte,
   input  logic        req_byte_valid,
   input  logic        req_start_message,
   input  logic        req_emit_digest,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [31:0] rsp_digest_word,
   output logic [2:0]  rsp_word_index,
   output logic        rsp_last_word,
   output logic        rsp_length_overflow
);

   sha256sh_pkg::cmd_type cmd;
   sha256sh_pkg::sts_type sts;

   // Sequencer.
   sha256sh_ctrl u_ctrl (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_emit_digest (req_emit_digest),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .cmd             (cmd),
      .sts             (sts)
   );

   // Hash state and round engine.
   sha256sh_dp u_dp (
      .clock               (clock),
      .reset               (reset),
      .cmd                 (cmd),
      .sts                 (sts),
      .req_data_byte       (req_data_byte),
      .req_byte_valid      (req_byte_valid),
      .req_start_message   (req_start_message),
      .rsp_digest_word     (rsp_digest_word),
      .rsp_word_index      (rsp_word_index),
      .rsp_last_word       (rsp_last_word),
      .rsp_length_overflow (rsp_length_overflow)
   );

endmodule

// File: test/sha256_stream_hash_tb.sv
// ----------------------------------------------------------------------------
// sha256_stream_hash_tb
// Self-checking bench: byte streams go in through the request channel and a
// running SHA-256 model predicts every digest word that comes back.
// ----------------------------------------------------------------------------

// Running SHA-256 model with a queue of digest words still to arrive.
class sha256_digest_board;
   typedef bit [31:0] hash_type[8];
   typedef bit [31:0] block_type[16];
   typedef struct packed {
      bit [31:0] word;
      bit [2:0]  index;
      bit        last;
      bit        ovf;
   } digest_beat_type;

   hash_type                 run_hash;
   block_type                run_block;
   bit [sha256sh_pkg::LEN_W-1:0] byte_count;
   bit                       ovf_seen;
   digest_beat_type          due_words[$];
   int                       errors;

   function void restart_message();
      foreach (run_hash[i]) run_hash[i] = sha256sh_pkg::IV_TABLE[i];
      foreach (run_block[i]) run_block[i] = '0;
      byte_count = '0;
      ovf_seen = 1'b0;
   endfunction

   function bit [31:0] rotr(bit [31:0] v, int n);
      return (v >> n) | (v << (32 - n));
   endfunction

   function void compress(ref hash_type h, input block_type blk);
      bit [31:0] w[64];
      bit [31:0] a, b, c, d, e, f, g, hh, t1, t2, s0, s1;
      for (int i = 0; i < 16; i++) w[i] = blk[i];
      for (int i = 16; i < 64; i++) begin
         s0 = rotr(w[i-15], 7) ^ rotr(w[i-15], 18) ^ (w[i-15] >> 3);
         s1 = rotr(w[i-2], 17) ^ rotr(w[i-2], 19) ^ (w[i-2] >> 10);
         w[i] = w[i-16] + s0 + w[i-7] + s1;
      end
      a = h[0]; b = h[1]; c = h[2]; d = h[3];
      e = h[4]; f = h[5]; g = h[6]; hh = h[7];
      for (int i = 0; i < 64; i++) begin
         t1 = hh + (rotr(e, 6) ^ rotr(e, 11) ^ rotr(e, 25)) + ((e & f) ^ (~e & g))
              + sha256sh_pkg::K_TABLE[i] + w[i];
         t2 = (rotr(a, 2) ^ rotr(a, 13) ^ rotr(a, 22)) ^ 32'h0;
         t2 = t2 + ((a & b) ^ (a & c) ^ (b & c));
         hh = g; g = f; f = e; e = d + t1;
         d = c; c = b; b = a; a = t1 + t2;
      end
      h[0] += a; h[1] += b; h[2] += c; h[3] += d;
      h[4] += e; h[5] += f; h[6] += g; h[7] += hh;
   endfunction

   function void place_byte(ref block_type blk, input int pos, input bit [7:0] v);
      int sh;
      sh = 24 - 8 * (pos % 4);
      blk[pos / 4] = (blk[pos / 4] & ~(32'hff << sh)) | (32'(v) << sh);
   endfunction

   function new();
      restart_message();
      errors = 0;
   endfunction

   // Notes one accepted request beat and queues any digest it causes.
   function void note_beat(bit [7:0] data, bit bv, bit start, bit emit);
      hash_type        h;
      block_type       blk;
      bit [63:0]       bits;
      int              pos;
      digest_beat_type beat;
      if (start) restart_message();
      if (bv) begin
         if (byte_count == sha256sh_pkg::LEN_MAX) begin
            ovf_seen = 1'b1;
         end else begin
            pos = int'(byte_count[5:0]);
            place_byte(run_block, pos, data);
            byte_count = byte_count + 1'b1;
            if (pos == 63) begin
               compress(run_hash, run_block);
               foreach (run_block[i]) run_block[i] = '0;
            end
         end
      end
      if (!emit) return;
      h = run_hash;
      blk = run_block;
      pos = int'(byte_count[5:0]);
      for (int i = pos; i < 64; i++) place_byte(blk, i, 8'h00);
      place_byte(blk, pos, sha256sh_pkg::PAD_BYTE);
      if (pos > int'(sha256sh_pkg::ROOM_POS)) begin
         compress(h, blk);
         foreach (blk[i]) blk[i] = '0;
      end
      bits = {byte_count, 3'b000};
      blk[14] = bits[63:32];
      blk[15] = bits[31:0];
      compress(h, blk);
      for (int i = 0; i < 8; i++) begin
         beat.word = h[i];
         beat.index = 3'(i);
         beat.last = (i == 7);
         beat.ovf = ovf_seen;
         due_words.push_back(beat);
      end
   endfunction

   // Checks one accepted result beat against the oldest expected word.
   function void check_word(bit [31:0] word, bit [2:0] index, bit last, bit ovf);
      digest_beat_type exp_beat;
      if (due_words.size() == 0) begin
         $error("unexpected digest beat: word %h index %0d", word, index);
         errors++;
         return;
      end
      exp_beat = due_words.pop_front();
      if (word !== exp_beat.word) begin
         $error("digest_word: expected %h, actual %h", exp_beat.word, word);
         errors++;
      end
      if (index !== exp_beat.index) begin
         $error("word_index: expected %0d, actual %0d", exp_beat.index, index);
         errors++;
      end
      if (last !== exp_beat.last) begin
         $error("last_word: expected %0d, actual %0d", exp_beat.last, last);
         errors++;
      end
      if (ovf !== exp_beat.ovf) begin
         $error("length_overflow: expected %0d, actual %0d", exp_beat.ovf, ovf);
         errors++;
      end
   endfunction

   function int pending();
      return due_words.size();
   endfunction
endclass

module sha256_stream_hash_tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int ITEM_TARGET = 120;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic [7:0]  req_data_byte = '0;
   logic        req_byte_valid = 1'b0;
   logic        req_start_message = 1'b0;
   logic        req_emit_digest = 1'b0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic [31:0] rsp_digest_word;
   logic [2:0]  rsp_word_index;
   logic        rsp_last_word;
   logic        rsp_length_overflow;

   sha256_digest_board board = new();
   bit  hold_rsp = 1'b0;
   bit  idle_on = 1'b1;
   int  sent_items = 0;

   sha256_stream_hash u_dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready),
      .req_data_byte(req_data_byte), .req_byte_valid(req_byte_valid),
      .req_start_message(req_start_message), .req_emit_digest(req_emit_digest),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready),
      .rsp_digest_word(rsp_digest_word), .rsp_word_index(rsp_word_index),
      .rsp_last_word(rsp_last_word), .rsp_length_overflow(rsp_length_overflow)
   );

   always #1 clock = ~clock;

   // Mostly short gaps, now and then a long one.
   function automatic int gap_cycles();
      int r;
      r = $urandom_range(0, 99);
      if (!idle_on || r < 60) return 0;
      if (r < 92) return $urandom_range(1, 3);
      return $urandom_range(10, 40);
   endfunction

   // Offers one request beat and waits for it to be taken.
   task automatic send_beat(input bit [7:0] d, input bit bv, input bit st, input bit em);
      int gap;
      req_valid <= 1'b1;
      req_data_byte <= d;
      req_byte_valid <= bv;
      req_start_message <= st;
      req_emit_digest <= em;
      do @(posedge clock); while (!req_ready);
      board.note_beat(d, bv, st, em);
      sent_items++;
      gap = gap_cycles();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   task automatic wait_drained();
      req_valid <= 1'b0;
      while (board.pending() != 0) @(posedge clock);
   endtask

   // One message of random content; lengths cluster short or near a block edge.
   task automatic send_message();
      int  len;
      bit  st_alone;
      len = ($urandom_range(0, 1) == 1) ? $urandom_range(0, 8) : $urandom_range(50, 70);
      st_alone = (len == 0) || ($urandom_range(0, 3) == 0);
      if (st_alone) send_beat(8'($urandom), 1'b0, 1'b1, len == 0);
      for (int i = 0; (i < len) && (sent_items < ITEM_TARGET); i++) begin
         if ($urandom_range(0, 19) == 0) send_beat(8'($urandom), 1'b0, 1'b0, 1'b0);
         send_beat(8'($urandom), 1'b1, (i == 0) && !st_alone,
                   (i == len - 1) || ($urandom_range(0, 15) == 0));
      end
   endtask

   // Result side: checks every beat and drives rsp_ready.
   initial begin
      forever begin
         @(posedge clock);
         if (!reset && rsp_valid && rsp_ready)
            board.check_word(rsp_digest_word, rsp_word_index, rsp_last_word,
                             rsp_length_overflow);
         if (hold_rsp) begin
            hold_rsp = 1'b0;
            rsp_ready <= 1'b0;
            repeat (400) @(posedge clock);
            rsp_ready <= 1'b1;
         end else begin
            rsp_ready <= !idle_on || ($urandom_range(0, 9) < 7) ||
                         ($urandom_range(0, 9) == 0 && rsp_ready);
         end
      end
   end

   // Stimulus.
   initial begin
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Empty message, then "abc", a repeated digest and edge byte values.
      send_beat(8'h00, 1'b0, 1'b1, 1'b1);
      send_beat(8'h61, 1'b1, 1'b1, 1'b0);
      send_beat(8'h62, 1'b1, 1'b0, 1'b0);
      send_beat(8'h63, 1'b1, 1'b0, 1'b1);
      send_beat(8'h5a, 1'b0, 1'b0, 1'b1);
      send_beat(8'hff, 1'b1, 1'b1, 1'b1);
      send_beat(8'h00, 1'b1, 1'b0, 1'b1);
      send_beat(8'haa, 1'b0, 1'b0, 1'b0);
      send_beat(8'h55, 1'b0, 1'b1, 1'b0);
      send_beat(8'h00, 1'b0, 1'b0, 1'b1);
      send_beat(8'h80, 1'b1, 1'b1, 1'b1);
      wait_drained();

      // Receiver holds off while requests keep coming, so the block backs up.
      hold_rsp = 1'b1;
      idle_on = 1'b0;
      for (int i = 0; i < 6; i++) send_beat(8'($urandom), 1'b1, i == 0, 1'b1);
      wait_drained();

      // Random messages, with an idle-free stretch in the middle.
      idle_on = 1'b1;
      while (sent_items < ITEM_TARGET) begin
         idle_on = !(sent_items > 60 && sent_items < 90);
         send_message();
      end
      idle_on = 1'b1;
      wait_drained();
      repeat (300) @(posedge clock);
      if (board.errors == 0 && board.pending() == 0) begin
         $display("sha256_stream_hash_tb: done, clean");
      end else begin
         $display("sha256_stream_hash_tb: done, errors");
      end
      $finish;
   end

   // Watchdog.
   initial begin
      #2000000;
      $display("sha256_stream_hash_tb: done, errors");
      $finish;
   end
endmodule
